// ===== src/madt_entry_stream_parser_unit_defines.svh =====
// Assertion macros shared by the parser top level.
`ifndef MADT_ENTRY_STREAM_PARSER_UNIT_DEFINES_SVH
`define MADT_ENTRY_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MADT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("madt parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MADT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("madt parser: next-cycle check failed");

`endif

// ===== src/madt_pkg.sv =====
// Shared types and constants of the interrupt-controller table entry parser.
`timescale 1ns / 1ps

package madt_pkg;

   // Entry type codes and minimum lengths that yield a record
   localparam logic [7:0] ENTRY_TYPE_CONTROLLER = 8'd1;
   localparam logic [7:0] ENTRY_TYPE_OVERRIDE   = 8'd2;
   localparam logic [7:0] MIN_LEN_CONTROLLER    = 8'd12;
   localparam logic [7:0] MIN_LEN_OVERRIDE      = 8'd10;

   // Record kind codes
   localparam logic KIND_CONTROLLER = 1'b0;
   localparam logic KIND_OVERRIDE   = 1'b1;

   // Body bytes kept for record assembly (entry bytes 2..11)
   localparam int CAP_BYTES = 10;
   localparam int CAP_IDX_W = $clog2(CAP_BYTES);

   // Fixed counter widths
   localparam int CTRL_CNT_W = 4;
   localparam int OVR_CNT_W  = 6;
   localparam int SLOT_W     = 5;

   // One classified word handed from front to back
   typedef struct packed {
      logic [7:0]           data;
      logic                 cap_en;
      logic [CAP_IDX_W-1:0] cap_idx;
      logic                 emit;
      logic                 kind;
      logic [SLOT_W-1:0]    slot;
   } cmd_type;

   // Queue status seen by the front and the top level
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== src/madt_entry_stream_parser_unit.sv =====
// Top level of the interrupt-controller table entry stream parser.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data_byte, req_first_byte
//   rsp      out        rsp_valid/rsp_ready    record fields, one register stage
//   csr      in         csr_valid/csr_ready    csr_data (entry area length)
//
// One byte per cycle while the queue has room; records go via the queue to the output register.
// The front classifies each byte in the cycle it is taken; a 4-word queue decouples it
// from the back, which owns the capture bytes and the output register.
// Reset is synchronous; it clears position, counts, queue and output valid.
// With rsp stalled and a record held, the next record word waits at the queue head; once
// four words are queued req_ready drops (type and length bytes take no slot). csr_ready is high.
`timescale 1ns / 1ps
`include "madt_entry_stream_parser_unit_defines.svh"

module madt_entry_stream_parser_unit #(
   parameter int MAX_CONTROLLERS = 8,
   parameter int MAX_OVERRIDES   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_kind,
   output logic [4:0]  rsp_slot,
   output logic [7:0]  rsp_controller_id,
   output logic [31:0] rsp_mmio_address,
   output logic [31:0] rsp_gsi_number,
   output logic [7:0]  rsp_source_bus,
   output logic [7:0]  rsp_legacy_irq,
   output logic [15:0] rsp_override_flags
);

   logic                   push;
   madt_pkg::cmd_type      push_cmd;
   logic                   pop;
   madt_pkg::cmd_type      pop_cmd;
   madt_pkg::q_status_type q_status;

   madt_front #(
      .MAX_CONTROLLERS (MAX_CONTROLLERS),
      .MAX_OVERRIDES   (MAX_OVERRIDES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .q_status       (q_status),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   madt_queue #(
      .DEPTH (4)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   madt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .cmd                (pop_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_slot           (rsp_slot),
      .rsp_controller_id  (rsp_controller_id),
      .rsp_mmio_address   (rsp_mmio_address),
      .rsp_gsi_number     (rsp_gsi_number),
      .rsp_source_bus     (rsp_source_bus),
      .rsp_legacy_irq     (rsp_legacy_irq),
      .rsp_override_flags (rsp_override_flags)
   );

   // Checks
   `MADT_ASSERT_NOW(a_ctrl_zero_fields, clock, reset,
      rsp_valid && rsp_record_kind == madt_pkg::KIND_CONTROLLER,
      rsp_source_bus == 8'd0 && rsp_legacy_irq == 8'd0 && rsp_override_flags == 16'd0)
   `MADT_ASSERT_NOW(a_ovr_zero_fields, clock, reset,
      rsp_valid && rsp_record_kind == madt_pkg::KIND_OVERRIDE,
      rsp_controller_id == 8'd0 && rsp_mmio_address == 32'd0)
   `MADT_ASSERT_NOW(a_ctrl_slot_range, clock, reset,
      rsp_valid && rsp_record_kind == madt_pkg::KIND_CONTROLLER,
      rsp_slot < 5'(MAX_CONTROLLERS))
   `MADT_ASSERT_NEXT(a_queue_drains, clock, reset,
      q_status.full && !push && pop,
      !q_status.full)

endmodule

// ===== src/madt_front.sv =====
// Front part: accepts input words, tracks entry position and counts, classifies each byte.
`timescale 1ns / 1ps

module madt_front #(
   parameter int MAX_CONTROLLERS = 8,
   parameter int MAX_OVERRIDES   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   input  madt_pkg::q_status_type q_status,
   output logic                  push,
   output madt_pkg::cmd_type     push_cmd
);

   logic [15:0] area_len_ff, area_len_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  off_ff, off_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  len_ff, len_in;
   logic [madt_pkg::CTRL_CNT_W-1:0] cc_ff, cc_in;
   logic [madt_pkg::OVR_CNT_W-1:0]  oc_ff, oc_in;
   logic        stop_ff, stop_in;

   logic        accept;
   logic [15:0] pos_v;
   logic [7:0]  off_v;
   logic [madt_pkg::CTRL_CNT_W-1:0] cc_v;
   logic [madt_pkg::OVR_CNT_W-1:0]  oc_v;
   logic        stop_v;
   logic [15:0] remaining;
   logic [7:0]  k;
   logic [7:0]  eff_len;
   logic        finish;

   assign csr_ready = 1'b1;
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Start-of-table marker clears position and counts before the byte is used
   always_comb begin
      pos_v  = req_first_byte ? 16'd0 : pos_ff;
      off_v  = req_first_byte ? 8'd0 : off_ff;
      cc_v   = req_first_byte ? '0 : cc_ff;
      oc_v   = req_first_byte ? '0 : oc_ff;
      stop_v = req_first_byte ? 1'b0 : stop_ff;
      remaining = (pos_v < area_len_ff) ? (area_len_ff - pos_v) : 16'd0;
      k = off_v - 8'd2;
   end

   // Byte classification and state update
   always_comb begin
      area_len_in = (csr_valid && csr_ready) ? csr_data : area_len_ff;
      pos_in  = pos_ff;
      off_in  = off_ff;
      type_in = type_ff;
      len_in  = len_ff;
      cc_in   = cc_ff;
      oc_in   = oc_ff;
      stop_in = stop_ff;
      finish  = 1'b0;
      eff_len = len_ff;
      push    = 1'b0;
      push_cmd = '0;
      push_cmd.data = req_data_byte;
      if (accept) begin
         pos_in  = pos_v;
         off_in  = off_v;
         cc_in   = cc_v;
         oc_in   = oc_v;
         stop_in = stop_v;
         if (!stop_v) begin
            priority if (off_v == 8'd0) begin
               // type byte
               if (remaining < 16'd2) begin
                  stop_in = 1'b1;
               end else begin
                  type_in = req_data_byte;
                  off_in  = 8'd1;
                  pos_in  = pos_v + 16'd1;
               end
            end else if (off_v == 8'd1) begin
               // length byte: zero or overrun stops parsing
               if (req_data_byte == 8'd0 ||
                   {9'd0, req_data_byte} > ({1'b0, remaining} + 17'd1)) begin
                  stop_in = 1'b1;
               end else begin
                  len_in  = req_data_byte;
                  eff_len = req_data_byte;
                  pos_in  = pos_v + 16'd1;
                  if (req_data_byte == 8'd2) begin
                     finish = 1'b1;
                     off_in = 8'd0;
                  end else begin
                     off_in = 8'd2;
                  end
               end
            end else begin
               // body byte
               push_cmd.cap_en  = (k < 8'(madt_pkg::CAP_BYTES));
               push_cmd.cap_idx = k[madt_pkg::CAP_IDX_W-1:0];
               pos_in = pos_v + 16'd1;
               if (({1'b0, off_v} + 9'd1) >= {1'b0, len_ff}) begin
                  finish = 1'b1;
                  off_in = 8'd0;
               end else begin
                  off_in = off_v + 8'd1;
               end
            end
            // entry complete: claim a slot if the table has room
            if (finish) begin
               if (type_ff == madt_pkg::ENTRY_TYPE_CONTROLLER &&
                   eff_len >= madt_pkg::MIN_LEN_CONTROLLER) begin
                  if (cc_v < madt_pkg::CTRL_CNT_W'(MAX_CONTROLLERS)) begin
                     push_cmd.emit = 1'b1;
                     push_cmd.kind = madt_pkg::KIND_CONTROLLER;
                     push_cmd.slot = madt_pkg::SLOT_W'(cc_v);
                     cc_in = cc_v + 1'b1;
                  end
               end else if (type_ff == madt_pkg::ENTRY_TYPE_OVERRIDE &&
                            eff_len >= madt_pkg::MIN_LEN_OVERRIDE) begin
                  if (oc_v < madt_pkg::OVR_CNT_W'(MAX_OVERRIDES)) begin
                     push_cmd.emit = 1'b1;
                     push_cmd.kind = madt_pkg::KIND_OVERRIDE;
                     push_cmd.slot = oc_v[madt_pkg::SLOT_W-1:0];
                     oc_in = oc_v + 1'b1;
                  end
               end
            end
            push = push_cmd.cap_en || push_cmd.emit;
         end
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         area_len_ff <= 16'd0;
         pos_ff  <= 16'd0;
         off_ff  <= 8'd0;
         type_ff <= 8'd0;
         len_ff  <= 8'd0;
         cc_ff   <= '0;
         oc_ff   <= '0;
         stop_ff <= 1'b0;
      end else begin
         area_len_ff <= area_len_in;
         pos_ff  <= pos_in;
         off_ff  <= off_in;
         type_ff <= type_in;
         len_ff  <= len_in;
         cc_ff   <= cc_in;
         oc_ff   <= oc_in;
         stop_ff <= stop_in;
      end
   end

endmodule

// ===== src/madt_queue.sv =====
// Short register queue of classified words between front and back.
`timescale 1ns / 1ps

module madt_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  madt_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output madt_pkg::cmd_type      pop_cmd,
   output madt_pkg::q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   madt_pkg::cmd_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_cmd = store_ff[rd_ff];

   // Pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/madt_back.sv =====
// Back part: keeps captured body bytes and assembles result words into the output register.
`timescale 1ns / 1ps

module madt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  madt_pkg::q_status_type q_status,
   input  madt_pkg::cmd_type      cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_record_kind,
   output logic [4:0]             rsp_slot,
   output logic [7:0]             rsp_controller_id,
   output logic [31:0]            rsp_mmio_address,
   output logic [31:0]            rsp_gsi_number,
   output logic [7:0]             rsp_source_bus,
   output logic [7:0]             rsp_legacy_irq,
   output logic [15:0]            rsp_override_flags
);

   logic [7:0]  cap_ff [madt_pkg::CAP_BYTES];
   logic [7:0]  view   [madt_pkg::CAP_BYTES];
   logic        valid_ff, valid_in;
   logic        out_free;
   logic        kind_ff, kind_in;
   logic [4:0]  slot_ff, slot_in;
   logic [7:0]  id_ff, id_in;
   logic [31:0] mmio_ff, mmio_in;
   logic [31:0] gsi_ff, gsi_in;
   logic [7:0]  bus_ff, bus_in;
   logic [7:0]  irq_ff, irq_in;
   logic [15:0] flags_ff, flags_in;

   // A word that emits needs the output register free or draining
   assign out_free = !valid_ff || rsp_ready;
   assign pop = !q_status.empty && (!cmd.emit || out_free);

   // Captured bytes with this word's byte merged in
   always_comb begin
      for (int i = 0; i < madt_pkg::CAP_BYTES; i++) begin
         view[i] = (cmd.cap_en && cmd.cap_idx == madt_pkg::CAP_IDX_W'(i)) ?
                   cmd.data : cap_ff[i];
      end
   end

   // Result assembly
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      slot_in  = slot_ff;
      id_in    = id_ff;
      mmio_in  = mmio_ff;
      gsi_in   = gsi_ff;
      bus_in   = bus_ff;
      irq_in   = irq_ff;
      flags_in = flags_ff;
      if (pop && cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cmd.kind;
         slot_in  = cmd.slot;
         unique case (cmd.kind)
            madt_pkg::KIND_CONTROLLER: begin
               id_in    = view[0];
               mmio_in  = {view[5], view[4], view[3], view[2]};
               gsi_in   = {view[9], view[8], view[7], view[6]};
               bus_in   = 8'd0;
               irq_in   = 8'd0;
               flags_in = 16'd0;
            end
            madt_pkg::KIND_OVERRIDE: begin
               id_in    = 8'd0;
               mmio_in  = 32'd0;
               gsi_in   = {view[5], view[4], view[3], view[2]};
               bus_in   = view[0];
               irq_in   = view[1];
               flags_in = {view[7], view[6]};
            end
            default: begin
               id_in = id_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload and capture registers, no reset
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      slot_ff  <= slot_in;
      id_ff    <= id_in;
      mmio_ff  <= mmio_in;
      gsi_ff   <= gsi_in;
      bus_ff   <= bus_in;
      irq_ff   <= irq_in;
      flags_ff <= flags_in;
      if (pop && cmd.cap_en) begin
         cap_ff[cmd.cap_idx] <= cmd.data;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_record_kind    = kind_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_controller_id  = id_ff;
   assign rsp_mmio_address   = mmio_ff;
   assign rsp_gsi_number     = gsi_ff;
   assign rsp_source_bus     = bus_ff;
   assign rsp_legacy_irq     = irq_ff;
   assign rsp_override_flags = flags_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the table entry stream parser: record tracker, drivers, stimulus.
`timescale 1ns / 1ps

// One record as it leaves the rsp channel, fields in port order
typedef struct packed {
   logic        kind;
   logic [4:0]  slot;
   logic [7:0]  controller_id;
   logic [31:0] mmio_address;
   logic [31:0] gsi_number;
   logic [7:0]  source_bus;
   logic [7:0]  legacy_irq;
   logic [15:0] override_flags;
} madt_record_type;

// Follows the parse byte by byte and holds the records still owed by the block
class madt_entry_tracker;
   int unsigned     max_ctrl;
   int unsigned     max_ovr;
   logic [15:0]     area_len;
   logic [15:0]     area_pos;
   logic [7:0]      entry_off;
   logic [7:0]      entry_code;
   logic [7:0]      entry_len;
   logic [7:0]      body [16];
   logic [3:0]      ctrl_count;
   logic [5:0]      ovr_count;
   bit              stopped;
   madt_record_type due_records [$];
   int              errors;
   int              words_taken;
   int              records_seen;

   function new(int unsigned max_c, int unsigned max_o);
      max_ctrl = max_c;
      max_ovr = max_o;
      area_len = '0;
      area_pos = '0;
      entry_off = '0;
      entry_code = '0;
      entry_len = '0;
      foreach (body[i]) body[i] = '0;
      ctrl_count = '0;
      ovr_count = '0;
      stopped = 1'b0;
      errors = 0;
      words_taken = 0;
      records_seen = 0;
   endfunction

   function void set_area_length(logic [15:0] value);
      area_len = value;
   endfunction

   // Last byte of an entry: queue a record if the kind qualifies and its table has room
   function void close_entry();
      madt_record_type rec;
      rec = '0;
      if (entry_code == madt_pkg::ENTRY_TYPE_CONTROLLER &&
          entry_len >= madt_pkg::MIN_LEN_CONTROLLER) begin
         if (ctrl_count >= max_ctrl) return;
         rec.kind = madt_pkg::KIND_CONTROLLER;
         rec.slot = 5'(ctrl_count);
         rec.controller_id = body[0];
         rec.mmio_address = {body[5], body[4], body[3], body[2]};
         rec.gsi_number = {body[9], body[8], body[7], body[6]};
         ctrl_count++;
         due_records.push_back(rec);
      end else if (entry_code == madt_pkg::ENTRY_TYPE_OVERRIDE &&
                   entry_len >= madt_pkg::MIN_LEN_OVERRIDE) begin
         if (ovr_count >= max_ovr) return;
         rec.kind = madt_pkg::KIND_OVERRIDE;
         rec.slot = ovr_count[4:0];
         rec.source_bus = body[0];
         rec.legacy_irq = body[1];
         rec.gsi_number = {body[5], body[4], body[3], body[2]};
         rec.override_flags = {body[7], body[6]};
         ovr_count++;
         due_records.push_back(rec);
      end
   endfunction

   // One accepted req word
   function void take_byte(logic [7:0] data, logic starts_table);
      int left;
      int k;
      words_taken++;
      if (starts_table) begin
         area_pos = '0;
         entry_off = '0;
         ctrl_count = '0;
         ovr_count = '0;
         stopped = 1'b0;
      end
      if (stopped) return;
      left = (area_pos < area_len) ? int'(area_len) - int'(area_pos) : 0;
      if (entry_off == 0) begin
         // entry start: type byte, needs room for type and length
         if (left < 2) begin
            stopped = 1'b1;
            return;
         end
         entry_code = data;
         foreach (body[i]) body[i] = '0;
         entry_off = 8'd1;
      end else if (entry_off == 1) begin
         // length byte: zero or past the area end halts the parse
         if (data == 0 || int'(data) > left + 1) begin
            stopped = 1'b1;
            return;
         end
         entry_len = data;
         entry_off = 8'd2;
         if (entry_len == 2) begin
            close_entry();
            entry_off = '0;
         end
      end else begin
         // body byte, only the first 16 are kept
         k = int'(entry_off) - 2;
         if (k < 16) body[k] = data;
         if (int'(entry_off) + 1 >= int'(entry_len)) begin
            close_entry();
            entry_off = '0;
         end else begin
            entry_off++;
         end
      end
      area_pos++;
   endfunction

   function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // One accepted rsp word against the oldest record owed
   function void match_record(madt_record_type got);
      madt_record_type want;
      if (due_records.size() == 0) begin
         $display("%0t: record with none expected, actual kind %0d slot %0d gsi 0x%0h",
                  $time, got.kind, got.slot, got.gsi_number);
         errors++;
         return;
      end
      want = due_records.pop_front();
      records_seen++;
      match_field("record_kind", want.kind, got.kind);
      match_field("slot", want.slot, got.slot);
      match_field("controller_id", want.controller_id, got.controller_id);
      match_field("mmio_address", want.mmio_address, got.mmio_address);
      match_field("gsi_number", want.gsi_number, got.gsi_number);
      match_field("source_bus", want.source_bus, got.source_bus);
      match_field("legacy_irq", want.legacy_irq, got.legacy_irq);
      match_field("override_flags", want.override_flags, got.override_flags);
   endfunction
endclass

module testbench;

   localparam int MAX_CONTROLLERS = 8;
   localparam int MAX_OVERRIDES   = 32;
   localparam int HALF_PERIOD     = 10;
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_CYCLES     = 150;
   localparam int STALL_LIMIT     = 2000;
   localparam int WORD_TARGET     = 500;

   typedef enum int {
      PH_WELL,
      PH_ZERO_AREA,
      PH_FULL_AREA,
      PH_NOISE,
      PH_BROKEN,
      PH_RESTART,
      PH_SATURATE
   } phase_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_first_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_record_kind;
   logic [4:0]  rsp_slot;
   logic [7:0]  rsp_controller_id;
   logic [31:0] rsp_mmio_address;
   logic [31:0] rsp_gsi_number;
   logic [7:0]  rsp_source_bus;
   logic [7:0]  rsp_legacy_irq;
   logic [15:0] rsp_override_flags;

   madt_entry_tracker tracker;
   logic [7:0]        word_q [$];
   bit                mark_q [$];
   bit                calm = 1'b0;
   bit                hold_request = 1'b0;
   int                phase_count = 0;

   madt_entry_stream_parser_unit #(
      .MAX_CONTROLLERS(MAX_CONTROLLERS),
      .MAX_OVERRIDES(MAX_OVERRIDES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_first_byte(req_first_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_record_kind(rsp_record_kind),
      .rsp_slot(rsp_slot),
      .rsp_controller_id(rsp_controller_id),
      .rsp_mmio_address(rsp_mmio_address),
      .rsp_gsi_number(rsp_gsi_number),
      .rsp_source_bus(rsp_source_bus),
      .rsp_legacy_irq(rsp_legacy_irq),
      .rsp_override_flags(rsp_override_flags)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Handshake monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.set_area_length(csr_data);
         if (req_valid && req_ready) tracker.take_byte(req_data_byte, req_first_byte);
         if (rsp_valid && rsp_ready)
            tracker.match_record({rsp_record_kind, rsp_slot, rsp_controller_id,
                                  rsp_mmio_address, rsp_gsi_number, rsp_source_bus,
                                  rsp_legacy_irq, rsp_override_flags});
      end
   end

   // Watchdog: ends the run after a long stretch with no handshake at all
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: random stalls, or one long hold-off on request
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready = calm || ($urandom_range(0, 99) >= 26);
         end
      end
   end

   function automatic void push_word(logic [7:0] value);
      word_q.push_back(value);
      mark_q.push_back(1'b0);
   endfunction

   function automatic void push_entry(logic [7:0] code, logic [7:0] len);
      push_word(code);
      push_word(len);
      for (int i = 2; i < int'(len); i++) push_word(8'($urandom));
   endfunction

   // Mostly the minimum length, sometimes longer, short or past the captured bytes
   function automatic logic [7:0] entry_length(logic [7:0] least);
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return least;
      if (r < 8) return least + 8'($urandom_range(1, 12));
      if (r < 9) return 8'($urandom_range(2, int'(least) - 1));
      return 8'($urandom_range(20, 40));
   endfunction

   function automatic int push_random_entry();
      logic [7:0] code;
      logic [7:0] len;
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         code = madt_pkg::ENTRY_TYPE_CONTROLLER;
         len = entry_length(madt_pkg::MIN_LEN_CONTROLLER);
      end else if (r < 8) begin
         code = madt_pkg::ENTRY_TYPE_OVERRIDE;
         len = entry_length(madt_pkg::MIN_LEN_OVERRIDE);
      end else begin
         do code = 8'($urandom);
         while (code == madt_pkg::ENTRY_TYPE_CONTROLLER ||
                code == madt_pkg::ENTRY_TYPE_OVERRIDE);
         len = 8'($urandom_range(2, 12));
      end
      push_entry(code, len);
      return int'(len);
   endfunction

   function automatic int push_table(int entries);
      int total;
      total = 0;
      for (int i = 0; i < entries; i++) total += push_random_entry();
      return total;
   endfunction

   // Drivers: all of them start and end at a falling edge
   task automatic write_area_length(logic [15:0] value);
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_words();
      while (word_q.size() != 0) begin
         // idle cycles before about a quarter of the words, repeated with the same odds
         if (!calm && $urandom_range(0, 99) < 26) begin
            req_valid = 1'b0;
            do @(negedge clock);
            while ($urandom_range(0, 99) < 26);
         end
         req_valid = 1'b1;
         req_data_byte = word_q.pop_front();
         req_first_byte = mark_q.pop_front();
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid = 1'b0;
   endtask

   // Wait for every owed record, then let the pipeline run empty
   task automatic drain_records();
      while (tracker.due_records.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One table: build the words, set the area length while idle, send, drain
   task automatic run_phase(phase_style_type style);
      int          span;
      int          extra;
      int          head;
      int          ctrl_left;
      int          ovr_left;
      logic [15:0] area;
      head = word_q.size();
      span = 0;
      unique case (style)
         PH_SATURATE: begin
            // one entry more than each table holds, both kinds interleaved
            ctrl_left = MAX_CONTROLLERS + 1;
            ovr_left = MAX_OVERRIDES + 1;
            while (ctrl_left + ovr_left > 0) begin
               if (ovr_left == 0 || (ctrl_left > 0 && $urandom_range(0, 3) == 0)) begin
                  push_entry(madt_pkg::ENTRY_TYPE_CONTROLLER, madt_pkg::MIN_LEN_CONTROLLER);
                  span += int'(madt_pkg::MIN_LEN_CONTROLLER);
                  ctrl_left--;
               end else begin
                  push_entry(madt_pkg::ENTRY_TYPE_OVERRIDE, madt_pkg::MIN_LEN_OVERRIDE);
                  span += int'(madt_pkg::MIN_LEN_OVERRIDE);
                  ovr_left--;
               end
            end
            area = 16'(span);
         end
         PH_ZERO_AREA: begin
            span = push_table($urandom_range(1, 2));
            area = '0;
         end
         PH_FULL_AREA: begin
            span = push_table($urandom_range(3, 8));
            area = '1;
         end
         PH_NOISE: begin
            repeat ($urandom_range(10, 40)) push_word(8'($urandom));
            area = 16'($urandom_range(0, 80));
         end
         PH_BROKEN: begin
            // good entries, then one with a zero or overrunning length, then junk
            span = push_table($urandom_range(2, 5));
            extra = $urandom_range(4, 30);
            push_word($urandom_range(0, 1) ? madt_pkg::ENTRY_TYPE_CONTROLLER
                                           : madt_pkg::ENTRY_TYPE_OVERRIDE);
            push_word($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(extra + 2, 255)));
            repeat ($urandom_range(2, 12)) push_word(8'($urandom));
            area = 16'(span + extra);
         end
         PH_RESTART: begin
            // a new table starts in the middle of this one
            span = push_table($urandom_range(3, 6));
            mark_q[head + $urandom_range(2, span - 1)] = 1'b1;
            area = 16'(span);
         end
         default: begin
            // area exact or a few bytes long, with a little trailing junk
            span = push_table($urandom_range(3, 8));
            area = 16'(span + $urandom_range(0, 3));
            repeat ($urandom_range(0, 4)) push_word(8'($urandom));
         end
      endcase
      // noise may carry on from the previous table
      mark_q[head] = (style == PH_NOISE) ? 1'($urandom) : 1'b1;
      write_area_length(area);
      send_words();
      drain_records();
      phase_count++;
   endtask

   initial begin : stimulus
      // controller with extreme fields, override, short override, then the area runs out
      logic [7:0] opening [26] = '{
         madt_pkg::ENTRY_TYPE_CONTROLLER, madt_pkg::MIN_LEN_CONTROLLER, 8'hFF, 8'h00,
         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
         madt_pkg::ENTRY_TYPE_OVERRIDE, madt_pkg::MIN_LEN_OVERRIDE, 8'h00, 8'hFF,
         8'h78, 8'h56, 8'h34, 8'h12, 8'hFF, 8'hFF,
         madt_pkg::ENTRY_TYPE_OVERRIDE, 8'h02,
         8'hA5, 8'h5A
      };
      int r;
      tracker = new(MAX_CONTROLLERS, MAX_OVERRIDES);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no table start mark after reset: parse begins at area byte 0
      foreach (opening[i]) push_word(opening[i]);
      write_area_length(16'd24);
      send_words();
      drain_records();

      // both tables past full with no idling, and one long receiver hold-off
      calm = 1'b1;
      hold_request = 1'b1;
      run_phase(PH_SATURATE);
      calm = 1'b0;

      run_phase(PH_ZERO_AREA);
      run_phase(PH_FULL_AREA);
      run_phase(PH_BROKEN);
      run_phase(PH_RESTART);
      run_phase(PH_NOISE);
      while (tracker.words_taken < WORD_TARGET) begin
         r = $urandom_range(0, 9);
         run_phase((r < 5) ? PH_WELL : phase_style_type'(r - 4));
      end

      $display("Run sent %0d bytes and matched %0d records over %0d tables,",
               tracker.words_taken, tracker.records_seen, phase_count);
      $display("with saturated tables, zero and full-span areas, broken and restarted tables.");
      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
